// ===== design/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and codes for the modular exponentiation block: control word
// layout, status bundle, microcode field codes and register indexes.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int PC_BITS       = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd1;

    // hold codes: what a step waits for before it completes
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_IN   = 2'd1;
    localparam logic [1:0] HOLD_OUT  = 2'd2;
    localparam logic [1:0] HOLD_MUL  = 2'd3;

    // branch codes: taken goes to target, otherwise pc + 1
    localparam logic [2:0] BR_NEXT    = 3'd0;
    localparam logic [2:0] BR_ALWAYS  = 3'd1;
    localparam logic [2:0] BR_NZERO   = 3'd2;
    localparam logic [2:0] BR_EBIT0   = 3'd3;
    localparam logic [2:0] BR_NOTLAST = 3'd4;

    // datapath actions, applied when the step completes
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_CAPTURE  = 3'd1;
    localparam logic [2:0] ACT_CNT_CLR  = 3'd2;
    localparam logic [2:0] ACT_CNT_INC  = 3'd3;
    localparam logic [2:0] ACT_LOAD_OUT = 3'd4;
    localparam logic [2:0] ACT_RES_ZERO = 3'd5;

    // multiplier operand selects
    localparam logic [1:0] A_ONE  = 2'd0;
    localparam logic [1:0] A_RES  = 2'd1;
    localparam logic [1:0] A_BASE = 2'd2;

    localparam logic [1:0] B_MSG  = 2'd0;
    localparam logic [1:0] B_ONE  = 2'd1;
    localparam logic [1:0] B_BASE = 2'd2;

    // product destination
    localparam logic DEST_BASE = 1'b0;
    localparam logic DEST_RES  = 1'b1;

    typedef struct packed {
        logic [1:0]         hold;
        logic [2:0]         br;
        logic [2:0]         act;
        logic [1:0]         a_sel;
        logic [1:0]         b_sel;
        logic               dest;
        logic [PC_BITS-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic mul_done;
        logic n_zero;
        logic ebit0;
        logic cnt_last;
    } stat_t;

    typedef struct packed {
        ctrl_t ctrl;
        logic  fire;
        logic  mul_go;
    } seq_out_t;

endpackage

// ===== design/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Interleaved modular multiplier: one multiplier bit per cycle, msb first,
// acc = (2*acc + bit*a) mod n with a single add and parallel compares.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
    parameter int WORD_BITS = mexp_pkg::DEF_WORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic [WORD_BITS-1:0] n,
    output logic                 done,
    output logic [WORD_BITS-1:0] prod
);
    import mexp_pkg::*;

    localparam int CW = $clog2(WORD_BITS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;

    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+2:0] diff1;
    logic [WORD_BITS+2:0] diff2;
    logic [WORD_BITS-1:0] step_val;

    // sum < 3n since acc < n and a < n
    always_comb
    begin
        sum   = {1'b0, acc_reg, 1'b0} + (b_reg[WORD_BITS-1] ? {2'b00, a_reg} : '0);
        diff1 = {1'b0, sum} - {3'b000, n};
        diff2 = {1'b0, sum} - {2'b00, n, 1'b0};
        if (!diff2[WORD_BITS+2])
        begin
            step_val = diff2[WORD_BITS-1:0];
        end
        else if (!diff1[WORD_BITS+2])
        begin
            step_val = diff1[WORD_BITS-1:0];
        end
        else
        begin
            step_val = sum[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            acc_next = step_val;
            b_next   = {b_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== design/mexp_seq.sv =====
// ----------------------------------------------------------------------------
// mexp_seq
// Microcode sequencer: program counter, control store and branch logic.
// A step completes when its hold condition is met, then branches or advances.
// ----------------------------------------------------------------------------
module mexp_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mexp_pkg::stat_t          stat,
    output mexp_pkg::seq_out_t       seq_out
);
    import mexp_pkg::*;

    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic               pending_reg, pending_next;
    ctrl_t              word;
    logic               ready;
    logic               taken;
    logic               mul_go;

    // control store
    always_comb
    begin
        word = '{hold: HOLD_NONE, br: BR_ALWAYS, act: ACT_NONE, a_sel: A_ONE,
                 b_sel: B_ONE, dest: DEST_RES, target: '0};
        case (pc_reg)
            4'd0:
            begin
                // wait for a request and capture it
                word.hold = HOLD_IN;
                word.br   = BR_NEXT;
                word.act  = ACT_CAPTURE;
            end
            4'd1:
            begin
                word.br     = BR_NZERO;
                word.target = 4'd9;
            end
            4'd2:
            begin
                // base = msg mod n
                word.hold  = HOLD_MUL;
                word.br    = BR_NEXT;
                word.act   = ACT_CNT_CLR;
                word.a_sel = A_ONE;
                word.b_sel = B_MSG;
                word.dest  = DEST_BASE;
            end
            4'd3:
            begin
                // result = 1 mod n
                word.hold  = HOLD_MUL;
                word.br    = BR_NEXT;
                word.a_sel = A_ONE;
                word.b_sel = B_ONE;
                word.dest  = DEST_RES;
            end
            4'd4:
            begin
                word.br     = BR_EBIT0;
                word.target = 4'd6;
            end
            4'd5:
            begin
                word.hold  = HOLD_MUL;
                word.br    = BR_NEXT;
                word.a_sel = A_RES;
                word.b_sel = B_BASE;
                word.dest  = DEST_RES;
            end
            4'd6:
            begin
                word.hold  = HOLD_MUL;
                word.br    = BR_NEXT;
                word.a_sel = A_BASE;
                word.b_sel = B_BASE;
                word.dest  = DEST_BASE;
            end
            4'd7:
            begin
                word.br     = BR_NOTLAST;
                word.act    = ACT_CNT_INC;
                word.target = 4'd4;
            end
            4'd8:
            begin
                word.hold   = HOLD_OUT;
                word.br     = BR_ALWAYS;
                word.act    = ACT_LOAD_OUT;
                word.target = 4'd0;
            end
            4'd9:
            begin
                // zero modulus gives zero
                word.br     = BR_ALWAYS;
                word.act    = ACT_RES_ZERO;
                word.target = 4'd8;
            end
            default:
            begin
                word.br     = BR_ALWAYS;
                word.target = 4'd0;
            end
        endcase
    end

    always_comb
    begin
        case (word.hold)
            HOLD_NONE: ready = 1'b1;
            HOLD_IN:   ready = stat.in_valid;
            HOLD_OUT:  ready = stat.out_free;
            HOLD_MUL:  ready = pending_reg && stat.mul_done;
            default:   ready = 1'b1;
        endcase

        case (word.br)
            BR_NEXT:    taken = 1'b0;
            BR_ALWAYS:  taken = 1'b1;
            BR_NZERO:   taken = stat.n_zero;
            BR_EBIT0:   taken = stat.ebit0;
            BR_NOTLAST: taken = !stat.cnt_last;
            default:    taken = 1'b0;
        endcase

        mul_go = (word.hold == HOLD_MUL) && !pending_reg;

        pc_next      = pc_reg;
        pending_next = pending_reg;
        if (mul_go)
        begin
            pending_next = 1'b1;
        end
        if (ready)
        begin
            pending_next = 1'b0;
            pc_next      = taken ? word.target : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            pending_reg <= pending_next;
        end
    end

    assign seq_out.ctrl   = word;
    assign seq_out.fire   = ready;
    assign seq_out.mul_go = mul_go;

endmodule

// ===== design/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply: power = msg^exponent mod modulus,
// driven by a microcoded sequencer over one interleaved modular multiplier.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 content
//  s_axis    in    tvalid / tready           message word
//  m_axis    out   tvalid / tready           power result
//  cfg       in    cfg_we                    modulus (0), exponent (1)
//
//  all modular multiplies run in the single shared multiplier
//  a request's length is set by the multiplier loop; zero modulus is fast
//  one request in work at a time; the next is taken while a result waits
//  reset: modulus 1, exponent 0, no result pending
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int WORD_BITS = mexp_pkg::DEF_WORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mexp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [WORD_BITS-1:0]                 cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // message_word
    input  logic [((WORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // power_result
    output logic [((WORD_BITS + 7) / 8) * 8-1:0] m_axis_tdata
);
    import mexp_pkg::*;

    localparam int TDATA_W = ((WORD_BITS + 7) / 8) * 8;
    localparam int CW      = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] modulus_reg, modulus_next;
    logic [WORD_BITS-1:0] exponent_reg, exponent_next;
    logic [WORD_BITS-1:0] msg_reg, msg_next;
    logic [WORD_BITS-1:0] base_reg, base_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic [WORD_BITS-1:0] out_data_reg, out_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    stat_t                stat;
    seq_out_t             seq_out;
    ctrl_t                ctrl;
    logic                 cnt_last;
    logic [WORD_BITS-1:0] mul_a;
    logic [WORD_BITS-1:0] mul_b;
    logic                 mul_done;
    logic [WORD_BITS-1:0] mul_prod;

    assign ctrl     = seq_out.ctrl;
    assign cnt_last = (cnt_reg == CW'(WORD_BITS - 1));

    assign stat.in_valid = s_axis_tvalid;
    assign stat.out_free = !out_valid_reg || m_axis_tready;
    assign stat.mul_done = mul_done;
    assign stat.n_zero   = (modulus_reg == '0);
    assign stat.ebit0    = !exponent_reg[cnt_reg];
    assign stat.cnt_last = cnt_last;

    mexp_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .stat    (stat),
        .seq_out (seq_out)
    );

    always_comb
    begin
        case (ctrl.a_sel)
            A_ONE:   mul_a = WORD_BITS'(1);
            A_RES:   mul_a = res_reg;
            A_BASE:  mul_a = base_reg;
            default: mul_a = WORD_BITS'(1);
        endcase
        case (ctrl.b_sel)
            B_MSG:   mul_b = msg_reg;
            B_ONE:   mul_b = WORD_BITS'(1);
            B_BASE:  mul_b = base_reg;
            default: mul_b = WORD_BITS'(1);
        endcase
    end

    mexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq_out.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .n     (modulus_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_comb
    begin
        modulus_next   = modulus_reg;
        exponent_next  = exponent_reg;
        msg_next       = msg_reg;
        base_next      = base_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS:  modulus_next  = cfg_wdata;
                REG_EXPONENT: exponent_next = cfg_wdata;
                default:      ;
            endcase
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (seq_out.fire)
        begin
            if (ctrl.hold == HOLD_MUL)
            begin
                if (ctrl.dest == DEST_BASE)
                begin
                    base_next = mul_prod;
                end
                else
                begin
                    res_next = mul_prod;
                end
            end
            case (ctrl.act)
                ACT_NONE:    ;
                ACT_CAPTURE: msg_next = s_axis_tdata[WORD_BITS-1:0];
                ACT_CNT_CLR: cnt_next = '0;
                ACT_CNT_INC: cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                ACT_LOAD_OUT:
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                end
                ACT_RES_ZERO: res_next = '0;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= WORD_BITS'(1);
            exponent_reg  <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            exponent_reg  <= exponent_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg      <= msg_next;
        base_reg     <= base_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (ctrl.hold == HOLD_IN);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);

endmodule
